/* hdl/htc_pkg.sv */
// ----------------------------------------------------------------------------
// htc_pkg: shared types and constants for the Huffman tree codec
// Request and result payloads, request and result codes, sequencer states.
// ----------------------------------------------------------------------------
package htc_pkg;
   localparam int NUM_SYMBOLS = 16;
   localparam int NODE_COUNT  = 2 * NUM_SYMBOLS - 1;
   localparam int SYM_W       = 4;
   localparam int NODE_W      = 5;
   localparam int CNT_W       = 6;
   localparam int CODE_MAX    = 15;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_DECODE = 2'd2,
      REQ_BAD    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      RSP_BUILT  = 2'd0,
      RSP_CODE   = 2'd1,
      RSP_SYMBOL = 2'd2,
      RSP_ERROR  = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  symbol;
      logic [23:0] weight;
      logic        last;
      logic        code_bit;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [3:0]  symbol_out;
      logic [14:0] code_bits;
      logic [3:0]  code_length;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,      // copy leaf into node store, clear scan position
      ST_INS_SCAN,
      ST_INS_SHIFT,
      ST_MERGE_A,
      ST_MERGE_B,
      ST_MERGE_POP,
      ST_CODE,
      ST_LEAF,
      ST_OUT
   } state_type;
endpackage

/* hdl/htc_cmp.sv */
// ----------------------------------------------------------------------------
// htc_cmp: shared weight compare and saturating add unit
// One 32-bit saturating add and one 32-bit compare, shared by insert scan and merge.
// ----------------------------------------------------------------------------
module htc_cmp import htc_pkg::*; (
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] sum,
   output logic        a_le_b
);
   logic [32:0] raw;
   assign raw    = {1'b0, a} + {1'b0, b};
   assign sum    = raw[32] ? 32'hFFFF_FFFF : raw[31:0];
   assign a_le_b = (a <= b);
endmodule

/* hdl/huffman_tree_codec.sv */
// ----------------------------------------------------------------------------
// huffman_tree_codec: Huffman tree builder, encoder and bit decoder
// Encode and decode register the request, then form the result in ST_OUT;
// a load without last returns no result. A build walks the sorted list once
// per insert, one entry per cycle through the shared compare unit.
// Reset clears the tree-ready flag, leaf weights and the sequencer.
// ----------------------------------------------------------------------------
module huffman_tree_codec import htc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);
   logic [23:0] leaf_ff [NUM_SYMBOLS];
   logic [31:0] nw_ff   [NODE_COUNT];
   logic [NODE_W-1:0] nl_ff [NODE_COUNT];
   logic [NODE_W-1:0] nr_ff [NODE_COUNT];
   logic [NODE_W-1:0] wo_ff [NODE_COUNT];
   logic [14:0] cw_ff [NODE_COUNT];
   logic [CNT_W-1:0] cl_ff [NODE_COUNT];
   logic [14:0] code_ff [NUM_SYMBOLS];
   logic [3:0]  size_ff [NUM_SYMBOLS];

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;     // list length
   logic [CNT_W-1:0] pos_ff, pos_in;     // scan / shift position
   logic [CNT_W-1:0] idx_ff, idx_in;     // node being inserted / walked
   logic [CNT_W-1:0] next_ff, next_in;   // next merged node number
   logic [NODE_W-1:0] a_ff, a_in;
   logic [NODE_W-1:0] root_ff, root_in, walk_ff, walk_in;
   logic ready_ff, ready_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;
   req_type_type req_ff, req_in;

   logic [31:0] cmp_a, cmp_b, cmp_sum;
   logic        cmp_le;
   htc_cmp u_cmp (.a(cmp_a), .b(cmp_b), .sum(cmp_sum), .a_le_b(cmp_le));

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   logic [NODE_W-1:0] idx_n, pos_n, wn, nxt_n;
   assign idx_n = idx_ff[NODE_W-1:0];
   assign pos_n = pos_ff[NODE_W-1:0];
   assign nxt_n = next_ff[NODE_W-1:0];
   assign wn    = (walk_ff < NODE_W'(NUM_SYMBOLS)) ? root_ff : walk_ff;

   always_comb begin
      cmp_a = nw_ff[wo_ff[pos_n]];
      cmp_b = nw_ff[idx_n];
      if (state_ff == ST_MERGE_B) begin
         cmp_a = nw_ff[a_ff];
         cmp_b = nw_ff[wo_ff[1]];
      end
   end

   always_comb begin
      logic [NODE_W-1:0] dn;
      state_in = state_ff; cnt_in = cnt_ff; pos_in = pos_ff; idx_in = idx_ff;
      next_in = next_ff; a_in = a_ff; root_in = root_ff; walk_in = walk_ff;
      ready_in = ready_ff; rv_in = rv_ff; rsp_in = rsp_ff; req_in = req_ff;
      dn = '0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (state_ff)
         ST_IDLE: if (accept) begin
            req_in = req_data;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_in = '{RSP_ERROR, 4'd0, 15'd0, 4'd0};
            state_in = ST_IDLE;
            case (req_kind_type'(req_ff.req_type))
               REQ_LOAD: if (req_ff.last) begin
                  cnt_in = '0; idx_in = '0; next_in = CNT_W'(NUM_SYMBOLS);
                  state_in = ST_INIT;
               end
               REQ_ENCODE: begin
                  if (ready_ff)
                     rsp_in = '{RSP_CODE, req_ff.symbol, code_ff[req_ff.symbol],
                                size_ff[req_ff.symbol]};
                  rv_in = 1'b1;
               end
               REQ_DECODE: if (!ready_ff) rv_in = 1'b1;
               else begin
                  dn = req_ff.code_bit ? nr_ff[wn] : nl_ff[wn];
                  if (dn >= NODE_W'(NODE_COUNT)) dn = root_ff;
                  if (dn < NODE_W'(NUM_SYMBOLS)) begin
                     walk_in = root_ff;
                     rsp_in = '{RSP_SYMBOL, dn[3:0], 15'd0, 4'd0};
                     rv_in = 1'b1;
                  end else walk_in = dn;
               end
               default: rv_in = 1'b1;
            endcase
         end
         ST_INIT: begin
            pos_in = '0;
            state_in = ST_INS_SCAN;
         end
         ST_INS_SCAN: begin
            if (pos_ff < cnt_ff && cmp_le) pos_in = pos_ff + 1'b1;
            else begin
               idx_in = {idx_ff};
               a_in = NODE_W'(cnt_ff);  // shift cursor
               state_in = ST_INS_SHIFT;
            end
         end
         ST_INS_SHIFT: begin
            if (a_ff > pos_n) a_in = a_ff - 1'b1;
            else begin
               cnt_in = cnt_ff + 1'b1;
               if (idx_ff < CNT_W'(NUM_SYMBOLS - 1)) begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ST_INIT;
               end else if (cnt_ff + 1'b1 >= 2 && next_ff < CNT_W'(NODE_COUNT))
                  state_in = ST_MERGE_A;
               else begin
                  // first code cycle latches the root
                  idx_in = CNT_W'(NUM_SYMBOLS - 1);
                  state_in = ST_CODE;
               end
            end
         end
         ST_MERGE_A: begin
            a_in = wo_ff[0];
            state_in = ST_MERGE_B;
         end
         ST_MERGE_B: begin
            pos_in = '0;
            state_in = ST_MERGE_POP;
         end
         ST_MERGE_POP: begin
            // drop the two heads one entry per cycle
            if (pos_ff < cnt_ff - 2'd2) pos_in = pos_ff + 1'b1;
            else begin
               cnt_in = cnt_ff - 2'd2;
               idx_in = next_ff;
               next_in = next_ff + 1'b1;
               pos_in = '0;
               state_in = ST_INS_SCAN;
            end
         end
         ST_CODE: begin
            if (idx_ff == CNT_W'(NUM_SYMBOLS - 1) && cnt_ff != 0) begin
               root_in = wo_ff[0];
               idx_in = CNT_W'(NODE_COUNT - 1);
            end else if (idx_ff > CNT_W'(NUM_SYMBOLS)) idx_in = idx_ff - 1'b1;
            else begin
               idx_in = '0;
               state_in = ST_LEAF;
            end
            if (idx_ff == CNT_W'(NUM_SYMBOLS)) begin
               idx_in = '0;
               state_in = ST_LEAF;
            end
            cnt_in = '0;
         end
         ST_LEAF: begin
            if (idx_ff == CNT_W'(NUM_SYMBOLS - 1)) begin
               walk_in = root_ff; ready_in = 1'b1;
               rsp_in = '{RSP_BUILT, 4'd0, 15'd0, 4'd0};
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end else idx_in = idx_ff + 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // after a merge, the scan in INS_SCAN restarts from position zero and the
   // shift cursor in INS_SHIFT restarts from the list count.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rv_ff <= 1'b0; ready_ff <= 1'b0;
         root_ff <= '0; walk_ff <= '0;
         for (int i = 0; i < NUM_SYMBOLS; i++) leaf_ff[i] <= '0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; ready_ff <= ready_in;
         root_ff <= root_in; walk_ff <= walk_in;
         if (state_ff == ST_OUT && req_ff.req_type == REQ_LOAD)
            leaf_ff[req_ff.symbol] <= req_ff.weight;
         if (state_ff == ST_LEAF) leaf_ff[idx_ff[SYM_W-1:0]] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in; pos_ff <= pos_in; idx_ff <= idx_in; next_ff <= next_in;
      a_ff <= a_in; rsp_ff <= rsp_in; req_ff <= req_in;
      case (state_ff)
         ST_INIT: nw_ff[idx_n] <= {8'd0, leaf_ff[idx_ff[SYM_W-1:0]]};
         ST_INS_SHIFT:
            if (a_ff > pos_n) wo_ff[a_ff] <= wo_ff[a_ff - 1'b1];
            else wo_ff[pos_n] <= idx_n;
         ST_MERGE_B: begin
            nw_ff[nxt_n] <= cmp_sum;
            nl_ff[nxt_n] <= a_ff;
            nr_ff[nxt_n] <= wo_ff[1];
         end
         ST_MERGE_POP:
            if (pos_ff < cnt_ff - 2'd2) wo_ff[pos_n] <= wo_ff[pos_n + 2'd2];
         ST_CODE:
            if (idx_ff == CNT_W'(NUM_SYMBOLS - 1) && cnt_ff != 0) begin
               cw_ff[wo_ff[0]] <= '0;
               cl_ff[wo_ff[0]] <= '0;
            end else begin
               cw_ff[nl_ff[idx_n]] <= cw_ff[idx_n];
               cl_ff[nl_ff[idx_n]] <= cl_ff[idx_n] + 1'b1;
               cw_ff[nr_ff[idx_n]] <= (cl_ff[idx_n] < CNT_W'(CODE_MAX)) ?
                  (cw_ff[idx_n] | (15'd1 << cl_ff[idx_n][3:0])) : cw_ff[idx_n];
               cl_ff[nr_ff[idx_n]] <= cl_ff[idx_n] + 1'b1;
            end
         ST_LEAF: begin
            code_ff[idx_ff[SYM_W-1:0]] <= cw_ff[idx_n];
            size_ff[idx_ff[SYM_W-1:0]] <= (cl_ff[idx_n] > CNT_W'(CODE_MAX)) ?
               4'(CODE_MAX) : cl_ff[idx_n][3:0];
         end
         default: ;
      endcase
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept) else $error("transfer while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(rsp_ff))) else $error("rsp dropped");
   a_ready_after_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEAF && state_in == ST_IDLE) |=> ready_ff)
      else $error("build did not mark tree ready");
endmodule
